>>> hdl/hkm_pkg.sv
// ----------------------------------------------------------------------------
// hkm_pkg
// Shared field widths, operation codes, datapath commands and the
// command/status structures used between the merge controller and datapath.
// ----------------------------------------------------------------------------
package hkm_pkg;

  localparam int OP_W     = 2;
  localparam int SLOT_W   = 4;
  localparam int DATA_W   = 32;
  localparam int SRC_W    = 4;
  localparam int CFG_W    = 5;
  localparam int S_DATA_W = 40;
  localparam int S_USER_W = 3;
  localparam int M_DATA_W = 40;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;

  localparam int CMD_W = 5;

  localparam logic [CMD_W-1:0] C_NOP     = 5'd0;
  localparam logic [CMD_W-1:0] C_LOAD    = 5'd1;
  localparam logic [CMD_W-1:0] C_START   = 5'd2;
  localparam logic [CMD_W-1:0] C_CP_STEP = 5'd3;
  localparam logic [CMD_W-1:0] C_CP_RD1  = 5'd4;
  localparam logic [CMD_W-1:0] C_CP_RD2  = 5'd5;
  localparam logic [CMD_W-1:0] C_CP_WR1  = 5'd6;
  localparam logic [CMD_W-1:0] C_CP_WR2  = 5'd7;
  localparam logic [CMD_W-1:0] C_HP_INIT = 5'd8;
  localparam logic [CMD_W-1:0] C_HP_NEXT = 5'd9;
  localparam logic [CMD_W-1:0] C_SD_RD   = 5'd10;
  localparam logic [CMD_W-1:0] C_SD_HOLD = 5'd11;
  localparam logic [CMD_W-1:0] C_SD_LC   = 5'd12;
  localparam logic [CMD_W-1:0] C_SD_PUT  = 5'd13;
  localparam logic [CMD_W-1:0] C_SD_RC   = 5'd14;
  localparam logic [CMD_W-1:0] C_SD_CMP  = 5'd15;
  localparam logic [CMD_W-1:0] C_RD0     = 5'd16;
  localparam logic [CMD_W-1:0] C_NX_HAS  = 5'd17;
  localparam logic [CMD_W-1:0] C_NX_DEL1 = 5'd18;
  localparam logic [CMD_W-1:0] C_NX_DEL2 = 5'd19;

  typedef struct packed {
    logic [CMD_W-1:0] code;
    logic             in_ready;
    logic             load_out;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            has;
    logic            cnt_zero;
    logic            pj_zero;
    logic            pres_p;
    logic            hi_zero;
    logic            lc_ok;
    logic            sd_stop;
    logic            out_free;
  } status_t;

endpackage

>>> hdl/hkm_ram.sv
// ----------------------------------------------------------------------------
// hkm_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module hkm_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/hkm_datapath.sv
// ----------------------------------------------------------------------------
// hkm_datapath
// Heap storage, present bits, heap count, sift pointers, compare logic and
// the registered result stage of the merge.
// ----------------------------------------------------------------------------
module hkm_datapath import hkm_pkg::*; #(
  parameter int MAX_LISTS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic              in_valid,
  input  logic [OP_W-1:0]   in_op,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic              in_has,
  input  logic [DATA_W-1:0] in_value,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [DATA_W-1:0] min_value,
  output logic [SRC_W-1:0]  min_source,
  output logic              done_res
);

  localparam int IW = $clog2(MAX_LISTS);
  localparam int CW = $clog2(MAX_LISTS + 1);
  localparam int XW = IW + 2;
  localparam int VW = VALUE_WIDTH;
  localparam int EW = VW + IW;

  logic [CFG_W-1:0]     active;
  logic [OP_W-1:0]      op_r;
  logic [SLOT_W-1:0]    slot_r;
  logic                 has_r;
  logic [VW-1:0]        val_r;

  logic [CW-1:0]        cnt, cnt_next;
  logic [CW-1:0]        pj, pj_next;
  logic [CW-1:0]        hi, hi_next;
  logic [IW-1:0]        cur, cur_next;
  logic [VW-1:0]        hold_v, hold_v_next;
  logic [IW-1:0]        hold_s, hold_s_next;
  logic                 hold_p, hold_p_next;
  logic [VW-1:0]        best_v, best_v_next;
  logic [IW-1:0]        best_s, best_s_next;
  logic                 best_c, best_c_next;
  logic [MAX_LISTS-1:0] present, present_next;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [EW-1:0]        ram_wdata;
  logic [IW-1:0]        ram_raddr;
  logic [EW-1:0]        ram_rdata;
  logic [VW-1:0]        rd_v;
  logic [IW-1:0]        rd_s;

  logic [CW-1:0]        size;
  logic [CW-1:0]        pj_m1, cnt_m1, hi_m1;
  logic [IW-1:0]        p_idx, last_idx, cnt_idx, slot_src;
  logic [XW-1:0]        lc_x, rc_x, cnt_x;
  logic [IW-1:0]        lc_idx, rc_idx;
  logic                 lc_ok, rc_ok, lc_less, rc_win, sd_stop, slot_ok, out_free;

  hkm_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_LISTS)
  ) u_heap_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  assign rd_v = ram_rdata[VW-1:0];
  assign rd_s = ram_rdata[EW-1:VW];

  always_comb begin
    if (int'(active) > MAX_LISTS) begin
      size = CW'(MAX_LISTS);
    end else begin
      size = CW'(active);
    end
  end

  assign pj_m1    = pj - CW'(1);
  assign cnt_m1   = cnt - CW'(1);
  assign hi_m1    = hi - CW'(1);
  assign p_idx    = pj_m1[IW-1:0];
  assign last_idx = cnt_m1[IW-1:0];
  assign cnt_idx  = cnt[IW-1:0];
  assign slot_src = IW'(slot_r);
  assign slot_ok  = int'(slot_r) < MAX_LISTS;

  assign lc_x    = {1'b0, cur, 1'b1};
  assign rc_x    = lc_x + XW'(1);
  assign cnt_x   = XW'(cnt);
  assign lc_ok   = lc_x < cnt_x;
  assign rc_ok   = rc_x < cnt_x;
  assign lc_idx  = lc_x[IW-1:0];
  assign rc_idx  = rc_x[IW-1:0];
  assign lc_less = $signed(rd_v) < $signed(hold_v);
  assign rc_win  = rc_ok && ($signed(rd_v) < $signed(best_v));
  assign sd_stop = !rc_win && !best_c;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cnt_next     = cnt;
    pj_next      = pj;
    hi_next      = hi;
    cur_next     = cur;
    hold_v_next  = hold_v;
    hold_s_next  = hold_s;
    hold_p_next  = hold_p;
    best_v_next  = best_v;
    best_s_next  = best_s;
    best_c_next  = best_c;
    present_next = present;
    ram_we       = 1'b0;
    ram_waddr    = cur;
    ram_wdata    = {hold_s, hold_v};
    ram_raddr    = '0;
    case (cmd.code)
      C_LOAD: begin
        if (slot_ok) begin
          ram_we                 = 1'b1;
          ram_waddr              = slot_src;
          ram_wdata              = {slot_src, val_r};
          present_next[slot_src] = has_r;
        end
      end
      C_START: begin
        cnt_next = size;
        pj_next  = size;
      end
      C_CP_STEP: begin
        pj_next = pj_m1;
      end
      C_CP_RD1: begin
        ram_raddr = p_idx;
      end
      C_CP_RD2: begin
        hold_v_next = rd_v;
        hold_s_next = rd_s;
        ram_raddr   = last_idx;
      end
      C_CP_WR1: begin
        ram_we                 = 1'b1;
        ram_waddr              = p_idx;
        ram_wdata              = ram_rdata;
        present_next[p_idx]    = present[last_idx];
        present_next[last_idx] = 1'b0;
      end
      C_CP_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = last_idx;
        ram_wdata = {hold_s, hold_v};
        cnt_next  = cnt_m1;
        pj_next   = pj_m1;
      end
      C_HP_INIT: begin
        hi_next = cnt >> 1;
      end
      C_HP_NEXT: begin
        hi_next  = hi_m1;
        cur_next = hi_m1[IW-1:0];
      end
      C_SD_RD: begin
        ram_raddr = cur;
      end
      C_SD_HOLD: begin
        hold_v_next = rd_v;
        hold_s_next = rd_s;
        hold_p_next = present[cur];
      end
      C_SD_LC: begin
        ram_raddr = lc_idx;
      end
      C_SD_PUT: begin
        ram_we            = 1'b1;
        present_next[cur] = hold_p;
      end
      C_SD_RC: begin
        if (lc_less) begin
          best_v_next = rd_v;
          best_s_next = rd_s;
          best_c_next = 1'b1;
        end else begin
          best_v_next = hold_v;
          best_s_next = hold_s;
          best_c_next = 1'b0;
        end
        ram_raddr = rc_idx;
      end
      C_SD_CMP: begin
        ram_we = 1'b1;
        if (rc_win) begin
          ram_wdata         = ram_rdata;
          present_next[cur] = present[rc_idx];
          cur_next          = rc_idx;
        end else if (best_c) begin
          ram_wdata         = {best_s, best_v};
          present_next[cur] = present[lc_idx];
          cur_next          = lc_idx;
        end else begin
          present_next[cur] = hold_p;
        end
      end
      C_RD0: begin
        ram_raddr = '0;
      end
      C_NX_HAS: begin
        hold_v_next = val_r;
        hold_s_next = rd_s;
        hold_p_next = present[0];
        cur_next    = '0;
      end
      C_NX_DEL1: begin
        best_v_next = rd_v;
        best_s_next = rd_s;
        cnt_next    = cnt_m1;
        ram_raddr   = last_idx;
      end
      C_NX_DEL2: begin
        hold_v_next           = rd_v;
        hold_s_next           = rd_s;
        hold_p_next           = present[cnt_idx];
        ram_we                = 1'b1;
        ram_waddr             = cnt_idx;
        ram_wdata             = {best_s, best_v};
        present_next[cnt_idx] = 1'b0;
        cur_next              = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= ACTIVE_RESET;
      cnt       <= '0;
      present   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        active <= cfg_wr_data;
      end
      cnt     <= cnt_next;
      present <= present_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && cmd.in_ready) begin
      op_r   <= in_op;
      slot_r <= in_slot;
      has_r  <= in_has;
      val_r  <= VW'($signed(in_value));
    end
    pj     <= pj_next;
    hi     <= hi_next;
    cur    <= cur_next;
    hold_v <= hold_v_next;
    hold_s <= hold_s_next;
    hold_p <= hold_p_next;
    best_v <= best_v_next;
    best_s <= best_s_next;
    best_c <= best_c_next;
    if (cmd.load_out) begin
      if (cnt == '0) begin
        min_value  <= '0;
        min_source <= '0;
        done_res   <= 1'b1;
      end else begin
        min_value  <= DATA_W'(rd_v);
        min_source <= SRC_W'(rd_s);
        done_res   <= 1'b0;
      end
    end
  end

  always_comb begin
    status.op       = op_r;
    status.has      = has_r;
    status.cnt_zero = (cnt == '0);
    status.pj_zero  = (pj == '0);
    status.pres_p   = present[p_idx];
    status.hi_zero  = (hi == '0);
    status.lc_ok    = lc_ok;
    status.sd_stop  = sd_stop;
    status.out_free = out_free;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_LISTS))
    else $error("heap count exceeds the number of slots");

  a_sift_descends: assert property (@(posedge clk) disable iff (rst)
    (cmd.code == C_SD_CMP && !sd_stop) |=> (cur > $past(cur)))
    else $error("sift-down did not move to a child position");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("result loaded while previous result still pending");

endmodule

>>> hdl/hkm_ctrl.sv
// ----------------------------------------------------------------------------
// hkm_ctrl
// Merge sequencer: decodes each accepted item and steps the datapath through
// slot loading, empty-slot compaction, heap build, sift-down and reporting.
// ----------------------------------------------------------------------------
module hkm_ctrl import hkm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DECODE  = 5'd1;
  localparam logic [4:0] S_CP_CHK  = 5'd2;
  localparam logic [4:0] S_CP_RD2  = 5'd3;
  localparam logic [4:0] S_CP_WR1  = 5'd4;
  localparam logic [4:0] S_CP_WR2  = 5'd5;
  localparam logic [4:0] S_HP_CHK  = 5'd6;
  localparam logic [4:0] S_SD_RD   = 5'd7;
  localparam logic [4:0] S_SD_HOLD = 5'd8;
  localparam logic [4:0] S_SD_LC   = 5'd9;
  localparam logic [4:0] S_SD_RC   = 5'd10;
  localparam logic [4:0] S_SD_CMP  = 5'd11;
  localparam logic [4:0] S_NX_HAS  = 5'd12;
  localparam logic [4:0] S_NX_DEL1 = 5'd13;
  localparam logic [4:0] S_NX_DEL2 = 5'd14;
  localparam logic [4:0] S_REP0    = 5'd15;
  localparam logic [4:0] S_REP1    = 5'd16;

  logic [4:0] state, state_next;
  logic       ret_heap, ret_heap_next;
  logic [4:0] ret_state;

  assign ret_state = ret_heap ? S_HP_CHK : S_REP0;

  always_comb begin
    state_next    = state;
    ret_heap_next = ret_heap;
    cmd.code      = C_NOP;
    cmd.in_ready  = 1'b0;
    cmd.load_out  = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.op)
          OP_LOAD: begin
            cmd.code   = C_LOAD;
            state_next = S_IDLE;
          end
          OP_START: begin
            cmd.code   = C_START;
            state_next = S_CP_CHK;
          end
          OP_NEXT: begin
            if (status.cnt_zero) begin
              state_next = S_REP0;
            end else if (status.has) begin
              cmd.code   = C_RD0;
              state_next = S_NX_HAS;
            end else begin
              cmd.code   = C_RD0;
              state_next = S_NX_DEL1;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_CP_CHK: begin
        if (status.pj_zero) begin
          cmd.code   = C_HP_INIT;
          state_next = S_HP_CHK;
        end else if (status.pres_p) begin
          cmd.code = C_CP_STEP;
        end else begin
          cmd.code   = C_CP_RD1;
          state_next = S_CP_RD2;
        end
      end
      S_CP_RD2: begin
        cmd.code   = C_CP_RD2;
        state_next = S_CP_WR1;
      end
      S_CP_WR1: begin
        cmd.code   = C_CP_WR1;
        state_next = S_CP_WR2;
      end
      S_CP_WR2: begin
        cmd.code   = C_CP_WR2;
        state_next = S_CP_CHK;
      end
      S_HP_CHK: begin
        if (status.hi_zero) begin
          state_next = S_REP0;
        end else begin
          cmd.code      = C_HP_NEXT;
          ret_heap_next = 1'b1;
          state_next    = S_SD_RD;
        end
      end
      S_SD_RD: begin
        cmd.code   = C_SD_RD;
        state_next = S_SD_HOLD;
      end
      S_SD_HOLD: begin
        cmd.code   = C_SD_HOLD;
        state_next = S_SD_LC;
      end
      S_SD_LC: begin
        if (status.lc_ok) begin
          cmd.code   = C_SD_LC;
          state_next = S_SD_RC;
        end else begin
          cmd.code   = C_SD_PUT;
          state_next = ret_state;
        end
      end
      S_SD_RC: begin
        cmd.code   = C_SD_RC;
        state_next = S_SD_CMP;
      end
      S_SD_CMP: begin
        cmd.code = C_SD_CMP;
        if (status.sd_stop) begin
          state_next = ret_state;
        end else begin
          state_next = S_SD_LC;
        end
      end
      S_NX_HAS: begin
        cmd.code      = C_NX_HAS;
        ret_heap_next = 1'b0;
        state_next    = S_SD_LC;
      end
      S_NX_DEL1: begin
        cmd.code   = C_NX_DEL1;
        state_next = S_NX_DEL2;
      end
      S_NX_DEL2: begin
        cmd.code = C_NX_DEL2;
        if (status.cnt_zero) begin
          state_next = S_REP0;
        end else begin
          ret_heap_next = 1'b0;
          state_next    = S_SD_LC;
        end
      end
      S_REP0: begin
        cmd.code   = C_RD0;
        state_next = S_REP1;
      end
      S_REP1: begin
        cmd.code = C_RD0;
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret_heap <= 1'b0;
    end else begin
      state    <= state_next;
      ret_heap <= ret_heap_next;
    end
  end

endmodule

>>> hdl/heap_kway_merge.sv
// ----------------------------------------------------------------------------
// heap_kway_merge
// K-way merge of sorted streams through a binary min-heap of value/source
// entries, with a sequencing controller and a heap datapath.
// ----------------------------------------------------------------------------
// One item is processed at a time. A load transfer is decoded and written into
// its slot. A next transfer first reads the root, then either puts the new
// value in its place or, when the source has run dry, moves the last entry
// up. The entry then sinks one heap level per left-child read, right-child
// read and compare (at most log2(MAX_LISTS) levels), is placed, and the root
// is reported. A next transfer that finds the heap empty, or that empties it,
// goes straight to the report. A start transfer compacts empty slots to the
// end of the heap with a read, read, write, write sequence per empty slot and
// a single step per filled one, then runs one sift-down per internal heap
// node before reporting.
// This step sequence is set by the single read port of the heap RAM, which the
// sift-down visits once per parent and child. The heap RAM needs no clearing
// after reset. A finished result waits in the output register while the next
// input transfer is already accepted.
module heap_kway_merge import hkm_pkg::*; #(
  parameter int MAX_LISTS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // slot [3:0], value [35:4], zero [39:36]
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // op [1:0], has_value [2]
  input  logic [S_USER_W-1:0] s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // min_value [31:0], min_source [35:32], zero [39:36]
  output logic [M_DATA_W-1:0] m_axis_tdata,
  // done_res [0]
  output logic                m_axis_tuser,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data
);

  cmd_t              cmd;
  status_t           status;
  logic [DATA_W-1:0] min_value;
  logic [SRC_W-1:0]  min_source;
  logic              done_res;

  hkm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .status  (status),
    .cmd     (cmd)
  );

  hkm_datapath #(
    .MAX_LISTS  (MAX_LISTS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_valid   (s_axis_tvalid),
    .in_op      (s_axis_tuser[OP_W-1:0]),
    .in_slot    (s_axis_tdata[SLOT_W-1:0]),
    .in_has     (s_axis_tuser[OP_W]),
    .in_value   (s_axis_tdata[SLOT_W+DATA_W-1:SLOT_W]),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .min_value  (min_value),
    .min_source (min_source),
    .done_res   (done_res)
  );

  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tdata  = {{(M_DATA_W - DATA_W - SRC_W){1'b0}}, min_source, min_value};
  assign m_axis_tuser  = done_res;

endmodule

>>> tb/sv/merge_order_checker.sv
// ----------------------------------------------------------------------------
// merge_order_checker
// Watches the input, output and register channels of the k-way merge,
// keeps its own copy of the heap, predicts the minimum reported for each
// start and next transfer, and compares every output transfer in order.
// ----------------------------------------------------------------------------
module merge_order_checker import hkm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  input  logic [S_USER_W-1:0] s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [M_DATA_W-1:0] m_axis_tdata,
  input  logic                m_axis_tuser,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  output int                  error_count,
  output int                  pending_count,
  output int                  result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LISTS = 16;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] min_value;
    logic [SRC_W-1:0]         min_source;
    logic                     done;
  } minimum_t;

  logic signed [DATA_W-1:0] heap_val [LISTS];
  logic [SRC_W-1:0]         heap_src [LISTS];
  logic                     heap_live [LISTS];
  int                       heap_size;
  logic [CFG_W-1:0]         lists_cfg;
  minimum_t                 expected_minima [$];
  int                       faults;
  int                       results_seen;

  function automatic void swap_entries(int a, int b);
    logic signed [DATA_W-1:0] v;
    logic [SRC_W-1:0]         s;
    logic                     p;
    v = heap_val[a];
    s = heap_src[a];
    p = heap_live[a];
    heap_val[a] = heap_val[b];
    heap_src[a] = heap_src[b];
    heap_live[a] = heap_live[b];
    heap_val[b] = v;
    heap_src[b] = s;
    heap_live[b] = p;
  endfunction

  // Ties keep the parent in place, and the left child wins over the right.
  function automatic void sink_entry(int start);
    int cur;
    int down;
    int lc;
    int rc;
    cur = start;
    while (cur < heap_size) begin
      down = cur;
      lc = 2 * cur + 1;
      rc = lc + 1;
      if (lc < heap_size && heap_val[lc] < heap_val[cur]) down = lc;
      if (rc < heap_size && heap_val[rc] < heap_val[down]) down = rc;
      if (down == cur) break;
      swap_entries(cur, down);
      cur = down;
    end
  endfunction

  function automatic minimum_t root_minimum();
    minimum_t m;
    if (heap_size == 0) begin
      m.min_value = '0;
      m.min_source = '0;
      m.done = 1'b1;
    end else begin
      m.min_value = heap_val[0];
      m.min_source = heap_src[0];
      m.done = 1'b0;
    end
    return m;
  endfunction

  function automatic bit predict_merge_step(input logic [OP_W-1:0] op,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic has,
                                            input logic signed [DATA_W-1:0] value,
                                            output minimum_t res);
    int size;
    int last;
    res = '0;
    case (op)
      OP_LOAD: begin
        heap_val[slot] = value;
        heap_src[slot] = slot;
        heap_live[slot] = has;
        return 1'b0;
      end
      OP_START: begin
        size = (lists_cfg > LISTS) ? LISTS : int'(lists_cfg);
        heap_size = size;
        last = size;
        // Empty slots are swapped to the shrinking end, walking downward.
        for (int p = size - 1; p >= 0; p--) begin
          if (!heap_live[p]) begin
            swap_entries(p, last - 1);
            last--;
            heap_size--;
          end
        end
        for (int i = heap_size / 2 - 1; i >= 0; i--) sink_entry(i);
        res = root_minimum();
        return 1'b1;
      end
      OP_NEXT: begin
        if (heap_size != 0) begin
          if (has) begin
            heap_val[0] = value;
          end else begin
            heap_size--;
            swap_entries(0, heap_size);
            heap_live[heap_size] = 1'b0;
          end
          sink_entry(0);
        end
        res = root_minimum();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    minimum_t got;
    minimum_t want;
    minimum_t res;
    if (rst) begin
      for (int i = 0; i < LISTS; i++) begin
        heap_val[i] = '0;
        heap_src[i] = '0;
        heap_live[i] = 1'b0;
      end
      heap_size = 0;
      lists_cfg = ACTIVE_RESET;
      expected_minima.delete();
      faults = 0;
      results_seen = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.min_value = m_axis_tdata[DATA_W-1:0];
        got.min_source = m_axis_tdata[DATA_W +: SRC_W];
        got.done = m_axis_tuser;
        results_seen++;
        if (expected_minima.size() == 0) begin
          faults++;
          if (faults <= REPORT_LIMIT)
            $display("unexpected result transfer: value %0d source %0d done %0b",
                     got.min_value, got.min_source, got.done);
        end else begin
          want = expected_minima.pop_front();
          if (got.min_value !== want.min_value || got.min_source !== want.min_source ||
              got.done !== want.done) begin
            faults++;
            if (faults <= REPORT_LIMIT)
              $display("result mismatch: expected value %0d source %0d done %0b, got value %0d source %0d done %0b",
                       want.min_value, want.min_source, want.done,
                       got.min_value, got.min_source, got.done);
          end
        end
      end
      if (cfg_wr_en) lists_cfg = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        if (predict_merge_step(s_axis_tuser[OP_W-1:0], s_axis_tdata[SLOT_W-1:0],
                               s_axis_tuser[OP_W], s_axis_tdata[SLOT_W +: DATA_W], res))
          expected_minima.push_back(res);
      end
    end
    error_count <= faults;
    pending_count <= expected_minima.size();
    result_count <= results_seen;
  end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the k-way merge. Drives directed corner cases,
// then well-formed merge runs of sorted streams mixed with random noise
// over several list-count settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb import hkm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LISTS = 16;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 44;
  localparam int SETTLE_CYCLES = 64;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh80000000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [S_USER_W-1:0] s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]    cfg_wr_data = '0;

  int error_count;
  int pending_count;
  int result_count;
  int src_idle = 0;
  int sink_stall = 0;
  int sent_items = 0;
  logic [CFG_W-1:0] lists_setting = ACTIVE_RESET;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) m_axis_tready <= ($urandom_range(99, 0) >= sink_stall);

  heap_kway_merge dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  merge_order_checker order_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .error_count   (error_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  task automatic send_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                           input logic has, input logic signed [DATA_W-1:0] value);
    while ($urandom_range(99, 0) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(S_DATA_W - SLOT_W - DATA_W){1'b0}}, value, slot};
    s_axis_tuser <= {has, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (op != OP_UNUSED) sent_items++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_lists(input logic [CFG_W-1:0] lists);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lists;
    lists_setting = lists;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void set_idling(int mode);
    case (mode)
      0: begin src_idle = 0;  sink_stall = 0;  end
      1: begin src_idle = 60; sink_stall = 0;  end
      2: begin src_idle = 0;  sink_stall = 60; end
      default: begin src_idle = 33; sink_stall = 33; end
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_head();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 25) return DATA_W'($urandom_range(4, 0)) - 2;
    if (roll < 35) return $urandom_range(1, 0) ? VALUE_MAX : VALUE_MIN;
    return $urandom;
  endfunction

  task automatic send_noise();
    logic [OP_W-1:0] op;
    op = OP_W'($urandom_range(3, 0));
    send_item(op, SLOT_W'($urandom_range(LISTS - 1, 0)), 1'($urandom_range(1, 0)),
              $urandom);
  endtask

  // One merge: load every active slot in shuffled order, start, then feed
  // each popped source a value no smaller than any live value fed so far, so all
  // streams stay sorted, until every stream runs dry.
  task automatic merge_run();
    int order [LISTS];
    logic live [LISTS];
    int lists;
    int remaining;
    int pick;
    int tmp;
    longint floor_val;
    longint v;
    logic signed [DATA_W-1:0] head;
    lists = (lists_setting > LISTS) ? LISTS : int'(lists_setting);
    for (int i = 0; i < LISTS; i++) begin
      order[i] = i;
      live[i] = 1'b0;
    end
    for (int i = lists - 1; i > 0; i--) begin
      pick = $urandom_range(i, 0);
      tmp = order[i];
      order[i] = order[pick];
      order[pick] = tmp;
    end
    floor_val = VALUE_MIN;
    remaining = 0;
    for (int i = 0; i < lists; i++) begin
      head = pick_head();
      live[order[i]] = ($urandom_range(99, 0) >= 20);
      if (live[order[i]]) begin
        remaining++;
        if (head > floor_val) floor_val = head;
      end
      send_item(OP_LOAD, SLOT_W'(order[i]), live[order[i]], head);
    end
    send_item(OP_START, SLOT_W'($urandom_range(LISTS - 1, 0)), 1'($urandom_range(1, 0)),
              $urandom);
    while (remaining > 0) begin
      if ($urandom_range(99, 0) >= 40) begin
        v = floor_val + longint'($urandom_range(3, 0));
        if (v > VALUE_MAX) v = VALUE_MAX;
        floor_val = v;
        send_item(OP_NEXT, SLOT_W'($urandom_range(LISTS - 1, 0)), 1'b1, DATA_W'(v));
      end else begin
        send_item(OP_NEXT, SLOT_W'($urandom_range(LISTS - 1, 0)), 1'b0, $urandom);
        remaining--;
      end
    end
    repeat ($urandom_range(2, 0))
      send_item(OP_NEXT, SLOT_W'($urandom_range(LISTS - 1, 0)), 1'($urandom_range(1, 0)),
                $urandom);
  endtask

  initial begin
    #8ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] phase_lists [PHASES];
    int goal;
    phase_lists = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd7, 5'd16, 5'd2};
    phase_lists[6] = CFG_W'($urandom_range(16, 2));
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    set_idling(3);
    send_item(OP_NEXT, 4'd0, 1'b1, 32'sd0);
    send_item(OP_UNUSED, 4'd15, 1'b1, -32'sd1);
    send_item(OP_LOAD, 4'd0, 1'b1, 32'sd5);
    send_item(OP_LOAD, 4'd1, 1'b1, VALUE_MIN);
    send_item(OP_LOAD, 4'd2, 1'b1, VALUE_MAX);
    send_item(OP_LOAD, 4'd3, 1'b0, 32'sd123);
    send_item(OP_LOAD, 4'd4, 1'b1, 32'sd5);
    send_item(OP_LOAD, 4'd5, 1'b1, 32'sd5);
    send_item(OP_LOAD, 4'd15, 1'b1, -32'sd7);
    send_item(OP_START, 4'd9, 1'b0, 32'sd0);
    send_item(OP_NEXT, 4'd0, 1'b1, -32'sd7);
    send_item(OP_NEXT, 4'd0, 1'b0, 32'sd0);
    send_item(OP_LOAD, 4'd0, 1'b1, 32'sd100);
    send_item(OP_NEXT, 4'd0, 1'b1, VALUE_MAX);
    repeat (6) send_item(OP_NEXT, 4'd0, 1'b0, 32'sd0);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      write_lists(phase_lists[p]);
      set_idling(p % 4);
      goal = sent_items + PHASE_ITEMS;
      while (sent_items < goal) begin
        if ($urandom_range(99, 0) < 15) begin
          repeat ($urandom_range(4, 1)) send_noise();
        end else begin
          merge_run();
        end
      end
      drain_results();
    end

    $display("Merged %0d reported minima from %0d input transfers.",
             result_count, sent_items);
    $display("List counts from 0 to 31, some above the slot count, ran under four idling patterns.");
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
